FILE: rtl/pip_pkg.sv
// Shared types and constants for the even-odd point-in-polygon core.
// Holds the beat structs, command codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package pip_pkg;

    localparam int COORD_W = 16;
    localparam int TOTAL_W = 9;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_TEST   = 2'd2;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
    } t_pip_in;

    typedef struct packed {
        logic                inside_res;
        logic [TOTAL_W-1:0]  vertex_total;
        logic                overflow;
    } t_pip_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the input beat and apply clear/append
        logic rd_en;     // read one vertex from the store
        logic rd_edge;   // the read closes an edge (not the priming read)
        logic load_out;  // move the pending result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;      // edge pipeline still holds work
        logic out_free;  // output register can take a beat this cycle
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the vertex store. No dependencies.
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pip_ctrl.sv
// Controller state machine for the point-in-polygon core.
// Sequences the vertex walk of a test and the result hand-off; uses pip_pkg.
`default_nettype none

module pip_ctrl
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire t_cmd                              i_in_cmd,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] i_count,
    input  wire t_dp_status                        i_status,
    output logic                                   o_in_stall,
    output t_dp_cmd                                o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_rd_addr
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_step, n_step;
    logic [CW-1:0]   rd_index;

    // The priming read fetches the last vertex, then vertices 0 .. n-1 follow.
    assign rd_index  = (r_step == '0) ? (i_count - CW'(1)) : (r_step - CW'(1));
    assign o_rd_addr = rd_index[AW-1:0];
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step       = '0;
                    if (i_in_cmd == CMD_TEST && i_count != '0) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_WALK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_edge = (r_step != '0);
                if (r_step == i_count) begin
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pip_dp.sv
// Datapath of the point-in-polygon core: vertex store, vertex count, the
// pipelined edge crossing test and the output register. Uses pip_pkg, pip_ram.
`default_nettype none

module pip_dp
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_pip_in                           i_in_data,
    input  wire t_dp_cmd                           i_cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]   i_rd_addr,
    input  wire logic                              i_out_stall,
    output t_dp_status                             o_status,
    output logic [$clog2(MAX_VERTICES+1)-1:0]      o_count,
    output logic                                   o_out_valid,
    output t_pip_out                               o_out_data
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic [CW-1:0]               r_count;
    logic signed [COORD_W-1:0]   r_tx, r_ty;
    logic                        r_flag;
    logic                        r_ovf;
    logic                        full;
    logic                        wr_en;

    logic [2*COORD_W-1:0]        rd_data;
    logic                        r_rd_v, r_rd_edge;
    logic signed [COORD_W-1:0]   r_bx, r_by;
    logic signed [COORD_W-1:0]   ax, ay;

    // Difference stage.
    logic                        r_e_v, r_e_str, r_e_dpos;
    logic signed [DW-1:0]        r_e_dx, r_e_d, r_e_ex, r_e_ey;
    // Product stage.
    logic                        r_m_v, r_m_str, r_m_dpos;
    logic signed [PW-1:0]        r_m_lhs, r_m_rhs;
    logic                        left;

    logic [CW+TOTAL_W-1:0]       count_ext;

    assign full  = (r_count >= CW'(MAX_VERTICES));
    assign wr_en = i_cmd.accept && (i_in_data.cmd == CMD_APPEND) && !full;

    pip_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_in_data.coord_x, i_in_data.coord_y}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_data)
    );

    assign ax = rd_data[2*COORD_W-1:COORD_W];
    assign ay = rd_data[COORD_W-1:0];

    // Count, test point and per-command flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_in_data.cmd == CMD_CLEAR) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tx  <= i_in_data.coord_x;
            r_ty  <= i_in_data.coord_y;
            r_ovf <= (i_in_data.cmd == CMD_APPEND) && full;
        end
    end

    // Read-data tag, aligned with the registered RAM output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v    <= 1'b0;
            r_rd_edge <= 1'b0;
        end else begin
            r_rd_v    <= i_cmd.rd_en;
            r_rd_edge <= i_cmd.rd_edge;
        end
    end

    // The edge runs from the previous vertex (B) to the current one (A).
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_bx <= ax;
            r_by <= ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_rd_v && r_rd_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_str  <= (ay > r_ty) != (r_by > r_ty);
        r_e_dpos <= (r_by > ay);
        r_e_dx   <= DW'(r_tx) - DW'(ax);
        r_e_d    <= DW'(r_by) - DW'(ay);
        r_e_ex   <= DW'(r_bx) - DW'(ax);
        r_e_ey   <= DW'(r_ty) - DW'(ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_str  <= r_e_str;
        r_m_dpos <= r_e_dpos;
        r_m_lhs  <= PW'(r_e_dx) * PW'(r_e_d);
        r_m_rhs  <= PW'(r_e_ex) * PW'(r_e_ey);
    end

    // Comparison direction follows the sign of the height difference.
    assign left = r_m_dpos ? (r_m_lhs < r_m_rhs) : (r_m_lhs > r_m_rhs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_flag <= 1'b0;
        end else if (r_m_v && r_m_str && left) begin
            r_flag <= !r_flag;
        end
    end

    // Output register.
    assign count_ext = {{TOTAL_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data.inside_res   <= r_flag;
            o_out_data.vertex_total <= count_ext[TOTAL_W-1:0];
            o_out_data.overflow     <= r_ovf;
        end
    end

    assign o_status.busy     = r_rd_v || r_e_v || r_m_v;
    assign o_status.out_free = !o_out_valid || !i_out_stall;
    assign o_count           = r_count;

endmodule

`default_nettype wire

FILE: rtl/point_in_polygon_even_odd_core.sv
// Top level of the even-odd point-in-polygon core.
// Joins pip_ctrl and pip_dp (which holds the pip_ram vertex store); uses pip_pkg.
`default_nettype none

// The core holds a polygon of up to MAX_VERTICES vertices and takes one
// command beat at a time: clear the polygon, append one vertex, or test one
// point. Every command beat returns exactly one result beat carrying the
// even-odd inside answer (tests only), the number of stored vertices after
// the command, and an overflow bit that is set when an append found the
// store full and was dropped. The crossing test is exact: the division of
// the textbook formula is replaced by a cross-multiplication of 17-bit
// differences whose compare direction follows the sign of the edge's height
// difference, so no rounding ever occurs. Any command but a test of a
// non-empty polygon goes from idle to the result state, which loads its
// result beat into the output register once that register is free, and
// the core then returns to idle. Such a test reads the vertex store through
// its single read port one vertex per cycle, first the last vertex to open
// the closing edge and then every vertex in order, and the three-stage edge
// pipeline (difference, multiply, compare-and-toggle) drains afterwards
// before the result state loads the result beat into the output register.
// One command is in the core at a time, and a finished result waits in the
// output register while the next command beat is accepted; that command's
// own result then waits until the receiver takes the earlier one, which
// adds the receiver's stall cycles. The vertex store needs no clearing after
// reset: only entries below the vertex count are ever read.
module point_in_polygon_even_odd_core
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_pip_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_pip_out      o_out_data
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    t_dp_cmd     dp_cmd;
    t_dp_status  dp_status;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count;

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .i_count    (count),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .o_rd_addr  (rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .i_rd_addr   (rd_addr),
        .i_out_stall (i_out_stall),
        .o_status    (dp_status),
        .o_count     (count),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // No command beat is taken while the edge pipeline still works.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.busy |-> o_in_stall)
        else $error("input beat accepted while edge pipeline busy");

    // One command at a time: an accepted beat blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("back-to-back input beats accepted");

    // The vertex count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for point_in_polygon_even_odd_core.
// Drives clear, append and test beats, predicts every result beat with an exact
// crossing-number model held here, and compares field by field. Uses pip_pkg.
module tb_top;
    import pip_pkg::*;

    localparam int     POLY_DEPTH  = 256;
    localparam int     FULL_SPAN   = 32768;
    localparam int     SETTLE_CYCS = 300;         // longer than a full-store test
    localparam longint RUN_LIMIT   = 40_000_000;  // far past any clean run

    // The fourth command code is unnamed in the package; the core only answers it.
    localparam t_cmd CMD_UNUSED = 2'd3;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_pip_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_pip_out o_out_data;

    // Polygon as this bench believes the core holds it.
    logic signed [COORD_W-1:0] poly_x [POLY_DEPTH];
    logic signed [COORD_W-1:0] poly_y [POLY_DEPTH];
    logic [TOTAL_W-1:0]        poly_count = '0;

    t_pip_out answers_due [$];
    t_pip_out head_answer;
    int       mismatch_count = 0;
    int       commands_sent  = 0;
    int       sender_idle_pct   = 0;
    int       receiver_stall_pct = 0;

    point_in_polygon_even_odd_core #(
        .MAX_VERTICES (POLY_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Even-odd parity over every edge from vertex j to vertex i. The division of
    // the crossing formula is replaced by a cross-multiplication whose compare
    // direction follows the sign of the edge's height difference.
    function automatic logic inside_polygon(input logic signed [COORD_W-1:0] tx,
                                            input logic signed [COORD_W-1:0] ty);
        logic                      parity;
        logic                      left_of;
        int                        i;
        int                        j;
        logic signed [COORD_W-1:0] ax, ay, bx, by;
        logic signed [COORD_W:0]   dy_edge, dx_edge, dx_pt, dy_pt;
        logic signed [2*COORD_W+1:0] lhs, rhs;
        parity = 1'b0;
        if (poly_count == 0) begin
            return 1'b0;
        end
        j = poly_count - 1;
        for (i = 0; i < poly_count; i++) begin
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[j];
            by = poly_y[j];
            if ((ay > ty) != (by > ty)) begin
                dy_edge = by - ay;
                dx_edge = bx - ax;
                dx_pt   = tx - ax;
                dy_pt   = ty - ay;
                lhs     = dx_pt * dy_edge;
                rhs     = dx_edge * dy_pt;
                left_of = (dy_edge > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left_of) begin
                    parity = ~parity;
                end
            end
            j = i;
        end
        return parity;
    endfunction

    // Applies one accepted command to the polygon copy and returns its result.
    function automatic t_pip_out polygon_step(input t_pip_in beat);
        t_pip_out res;
        res = '0;
        case (beat.cmd)
            CMD_CLEAR: begin
                poly_count = '0;
            end
            CMD_APPEND: begin
                if (poly_count < POLY_DEPTH) begin
                    poly_x[poly_count] = beat.coord_x;
                    poly_y[poly_count] = beat.coord_y;
                    poly_count++;
                end else begin
                    res.overflow = 1'b1;
                end
            end
            CMD_TEST: begin
                res.inside_res = inside_polygon(beat.coord_x, beat.coord_y);
            end
            default: begin
            end
        endcase
        res.vertex_total = poly_count;
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
        int v;
        if (span >= FULL_SPAN) begin
            // Full range, with the extremes pulled in now and then.
            if ($urandom_range(7) == 0) begin
                return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            return 16'($urandom);
        end
        v = int'($urandom_range(2 * span)) - span;
        return v[COORD_W-1:0];
    endfunction

    // Sends one beat. The beat is presented either right away, keeping valid
    // high from the previous beat, or after a random gap with valid low. The
    // expected result is queued at the edge that accepts the beat.
    task automatic send_beat(input t_cmd cmd, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        t_pip_in beat;
        beat.cmd     = cmd;
        beat.coord_x = x;
        beat.coord_y = y;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        answers_due.push_back(polygon_step(beat));
        commands_sent++;
    endtask

    // Lowers valid and holds off until every queued result has come back. Always
    // advances at least one edge so valid is not raised again in the same step.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    // Results sink: random stall, and a field-by-field compare on every beat.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_data);
                mismatch_count++;
            end else begin
                head_answer = answers_due.pop_front();
                if (o_out_data.inside_res !== head_answer.inside_res) begin
                    $error("inside_res: expected %0d, got %0d",
                           head_answer.inside_res, o_out_data.inside_res);
                    mismatch_count++;
                end
                if (o_out_data.vertex_total !== head_answer.vertex_total) begin
                    $error("vertex_total: expected %0d, got %0d",
                           head_answer.vertex_total, o_out_data.vertex_total);
                    mismatch_count++;
                end
                if (o_out_data.overflow !== head_answer.overflow) begin
                    $error("overflow: expected %0d, got %0d",
                           head_answer.overflow, o_out_data.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Tests on an empty store, a single vertex and a two-vertex degenerate
    // polygon, plus the unused command code.
    task automatic test_small_polygons();
        send_beat(CMD_TEST, 16'sd0, 16'sd0);
        send_beat(CMD_UNUSED, -16'sd1, -16'sd1);
        send_beat(CMD_APPEND, 16'sd5, 16'sd5);
        send_beat(CMD_TEST, 16'sd0, 16'sd5);
        send_beat(CMD_APPEND, -16'sd5, -16'sd5);
        send_beat(CMD_TEST, 16'sd0, 16'sd0);
    endtask

    // Square spanning the whole coordinate range: differences and products at
    // their widest, and points on a corner and on three of its sides.
    task automatic test_extreme_square();
        send_beat(CMD_CLEAR, 16'sh7FFF, 16'sh8000);
        send_beat(CMD_APPEND, 16'sh8000, 16'sh8000);
        send_beat(CMD_APPEND, 16'sh7FFF, 16'sh8000);
        send_beat(CMD_APPEND, 16'sh7FFF, 16'sh7FFF);
        send_beat(CMD_APPEND, 16'sh8000, 16'sh7FFF);
        send_beat(CMD_TEST, 16'sd0, 16'sd0);
        send_beat(CMD_TEST, 16'sh8000, 16'sh8000);
        send_beat(CMD_TEST, 16'sh7FFF, 16'sd0);
        send_beat(CMD_TEST, 16'sh8000, 16'sd0);
        send_beat(CMD_TEST, 16'sd0, 16'sh7FFF);
        send_beat(CMD_TEST, -16'sd1, -16'sd1);
    endtask

    // Triangle whose long edge is the full-range diagonal, with a descending
    // edge so the compare runs in the reversed direction; points just beside
    // the diagonal.
    task automatic test_extreme_diagonal();
        send_beat(CMD_CLEAR, 16'sd0, 16'sd0);
        send_beat(CMD_APPEND, 16'sh8000, 16'sh7FFF);
        send_beat(CMD_APPEND, 16'sh7FFF, 16'sh8000);
        send_beat(CMD_APPEND, 16'sh7FFF, 16'sh7FFF);
        send_beat(CMD_TEST, 16'sd0, 16'sd0);
        send_beat(CMD_TEST, 16'sd1, 16'sd0);
    endtask

    // Fills the store, pushes two appends into the full store and drains, then
    // tests the 256-vertex polygon and ends with unused, clear, append and test.
    task automatic test_full_store();
        int span;
        span = $urandom_range(1) ? FULL_SPAN : 2048;
        send_beat(CMD_CLEAR, 16'sd0, 16'sd0);
        repeat (POLY_DEPTH) begin
            send_beat(CMD_APPEND, rand_coord(span), rand_coord(span));
        end
        send_beat(CMD_APPEND, rand_coord(span), rand_coord(span));
        send_beat(CMD_APPEND, 16'sh7FFF, 16'sh8000);
        wait_drained();
        repeat (4) begin
            send_beat(CMD_TEST, rand_coord(span), rand_coord(span));
        end
        send_beat(CMD_UNUSED, 16'sd0, 16'sd0);
        send_beat(CMD_CLEAR, rand_coord(FULL_SPAN), rand_coord(FULL_SPAN));
        send_beat(CMD_APPEND, 16'sd3, -16'sd3);
        send_beat(CMD_TEST, 16'sd3, -16'sd3);
    endtask

    // One well-formed sequence: usually a clear, a small polygon and a few
    // tests. Tiny spans give collinear edges, horizontal edges and points on
    // vertices; test points are often snapped to a vertex, to a vertex height or
    // to the midpoint of two vertices. Skipped clears, stray unused commands and
    // long polygons make up the noise; overflow shows up when appends pile up.
    task automatic run_one_shape();
        int span;
        int n_vert;
        int n_tests;
        int k;
        int k2;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        case ($urandom_range(3))
            0:       span = 4;
            1:       span = 64;
            2:       span = 2048;
            default: span = FULL_SPAN;
        endcase
        if ($urandom_range(9) != 0) begin
            send_beat(CMD_CLEAR, rand_coord(FULL_SPAN), rand_coord(FULL_SPAN));
        end
        case ($urandom_range(19))
            0, 1:    n_vert = $urandom_range(2);
            2:       n_vert = $urandom_range(64, 13);
            default: n_vert = $urandom_range(12, 3);
        endcase
        repeat (n_vert) begin
            send_beat(CMD_APPEND, rand_coord(span), rand_coord(span));
            if ($urandom_range(39) == 0) begin
                send_beat(CMD_UNUSED, rand_coord(FULL_SPAN), rand_coord(FULL_SPAN));
            end
        end
        if ($urandom_range(29) == 0) begin
            wait_drained();
        end
        n_tests = $urandom_range(6, 1);
        repeat (n_tests) begin
            tx = rand_coord(span);
            ty = rand_coord(span);
            if (poly_count != 0) begin
                k  = $urandom_range(poly_count - 1);
                k2 = $urandom_range(poly_count - 1);
                case ($urandom_range(4))
                    2: begin
                        tx = poly_x[k];
                        ty = poly_y[k];
                    end
                    3: begin
                        ty = poly_y[k];
                    end
                    4: begin
                        tx = 16'((int'(poly_x[k]) + int'(poly_x[k2])) / 2);
                        ty = 16'((int'(poly_y[k]) + int'(poly_y[k2])) / 2);
                    end
                    default: begin
                    end
                endcase
            end
            send_beat(CMD_TEST, tx, ty);
        end
    endtask

    task automatic test_random_shapes(input int beat_budget);
        int stop_at;
        stop_at = commands_sent + beat_budget;
        while (commands_sent < stop_at) begin
            run_one_shape();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver stalling most of the time.
        set_idling(9, 70);
        test_small_polygons();
        test_extreme_square();
        test_extreme_diagonal();
        test_random_shapes(470);

        // Sender mostly idle, receiver rarely stalling.
        wait_drained();
        set_idling(70, 9);
        test_full_store();
        test_random_shapes(470);

        // Back-to-back beats on both sides.
        wait_drained();
        set_idling(0, 0);
        test_random_shapes(470);

        wait_drained();
        repeat (SETTLE_CYCS) @(posedge i_clk);
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
